/* rtl/ets_pkg.sv */
// shared types, constants and the character decoder for the expression token scanner
// no dependencies
package ets_pkg;

    localparam int MAX_TOKEN_CHARS_DEF = 256;
    localparam int QUEUE_DEPTH = 4;

    // token kinds
    localparam logic [3:0] K_INT      = 4'd0;
    localparam logic [3:0] K_ID       = 4'd1;
    localparam logic [3:0] K_ADDSUB   = 4'd2;
    localparam logic [3:0] K_INCDEC   = 4'd3;
    localparam logic [3:0] K_MULDIV   = 4'd4;
    localparam logic [3:0] K_ASSIGN   = 4'd5;
    localparam logic [3:0] K_LPAREN   = 4'd6;
    localparam logic [3:0] K_RPAREN   = 4'd7;
    localparam logic [3:0] K_AND      = 4'd8;
    localparam logic [3:0] K_OR       = 4'd9;
    localparam logic [3:0] K_XOR      = 4'd10;
    localparam logic [3:0] K_EOL      = 4'd11;
    localparam logic [3:0] K_EOF      = 4'd12;
    localparam logic [3:0] K_NUMID    = 4'd13;
    localparam logic [3:0] K_SYNTAX   = 4'd14;

    // kinds of a held character
    localparam logic [1:0] PK_INT    = 2'd0;
    localparam logic [1:0] PK_ID     = 2'd1;
    localparam logic [1:0] PK_ADDSUB = 2'd2;

    // characters
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] char_out;
        logic       token_first;
        logic       token_last;
        logic       run_last;
    } out_item_t;

    // one or two results caused by one input item
    typedef struct packed {
        logic      two;
        out_item_t r0;
        out_item_t r1;
    } res_pair_t;

    typedef struct packed {
        logic      push;
        res_pair_t pair;
    } push_t;

    function automatic logic [3:0] single_kind(logic [7:0] c);
        logic [3:0] k;
        unique case (c) inside
            CH_STAR, CH_SLASH: k = K_MULDIV;
            CH_EQ:             k = K_ASSIGN;
            CH_LPAREN:         k = K_LPAREN;
            CH_RPAREN:         k = K_RPAREN;
            CH_AMP:            k = K_AND;
            CH_BAR:            k = K_OR;
            CH_CARET:          k = K_XOR;
            CH_NL:             k = K_EOL;
            default:           k = K_SYNTAX;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || (c == CH_UNDER);
    endfunction

endpackage

/* rtl/ets_front.sv */
// front end: accepts characters, keeps the held character and classifies tokens
// depends on ets_pkg
module ets_front #(
    parameter int MaxTokenChars = ets_pkg::MAX_TOKEN_CHARS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ets_pkg::in_item_t  s_data,
    input  logic               q_full,
    output ets_pkg::push_t     q_push
);

    localparam int LenW = $clog2(MaxTokenChars + 1);

    logic            pv_reg, pv_next;
    logic [1:0]      pk_reg, pk_next;
    logic [7:0]      pc_reg, pc_next;
    logic            pf_reg, pf_next;
    logic [LenW-1:0] len_reg, len_next;

    logic                 accept;
    logic [7:0]           c;
    logic                 eoi;
    logic                 c_digit, c_letter;
    logic                 f_emit, f_hold;
    logic [1:0]           f_hkind;
    ets_pkg::out_item_t   f_res, flush_res;
    ets_pkg::out_item_t   r0, r1;
    logic                 two, any;
    logic                 full, cont;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        c        = s_data.char_in;
        eoi      = s_data.end_of_input;
        c_digit  = ets_pkg::is_digit(c);
        c_letter = ets_pkg::is_letter(c);

        // start of a fresh token
        f_emit  = 1'b0;
        f_hold  = 1'b0;
        f_hkind = ets_pkg::PK_INT;
        f_res   = '{token_kind: ets_pkg::single_kind(c), char_out: c,
                    token_first: 1'b1, token_last: 1'b1, run_last: 1'b1};
        if (eoi) begin
            f_emit           = 1'b1;
            f_res.token_kind = ets_pkg::K_EOF;
            f_res.char_out   = 8'd0;
        end else if (c == ets_pkg::CH_SPACE || c == ets_pkg::CH_TAB) begin
            f_emit = 1'b0;
        end else if (c_digit) begin
            f_hold  = 1'b1;
            f_hkind = ets_pkg::PK_INT;
        end else if (c_letter) begin
            f_hold  = 1'b1;
            f_hkind = ets_pkg::PK_ID;
        end else if (c == ets_pkg::CH_PLUS || c == ets_pkg::CH_MINUS) begin
            f_hold  = 1'b1;
            f_hkind = ets_pkg::PK_ADDSUB;
        end else begin
            f_emit = 1'b1;
        end

        flush_res = '{token_kind: (pk_reg == ets_pkg::PK_ADDSUB) ? ets_pkg::K_ADDSUB
                                                                  : {2'b00, pk_reg},
                      char_out: pc_reg, token_first: pf_reg, token_last: 1'b1,
                      run_last: 1'b1};

        full = (len_reg >= LenW'(MaxTokenChars));
        cont = !eoi && !full && ((pk_reg == ets_pkg::PK_INT) ? c_digit : (c_digit || c_letter));

        pv_next  = f_hold;
        pk_next  = f_hkind;
        pc_next  = c;
        pf_next  = 1'b1;
        len_next = LenW'(1);
        r0       = f_res;
        r1       = f_res;
        two      = 1'b0;
        any      = f_emit;

        if (pv_reg) begin
            if (pk_reg == ets_pkg::PK_ADDSUB) begin
                if (!eoi && c == pc_reg) begin
                    r0 = '{token_kind: ets_pkg::K_INCDEC, char_out: pc_reg,
                           token_first: 1'b1, token_last: 1'b0, run_last: 1'b0};
                    r1 = '{token_kind: ets_pkg::K_INCDEC, char_out: c,
                           token_first: 1'b0, token_last: 1'b1, run_last: 1'b1};
                    two     = 1'b1;
                    any     = 1'b1;
                    pv_next = 1'b0;
                end else begin
                    r0  = flush_res;
                    two = f_emit;
                    any = 1'b1;
                end
            end else if (cont) begin
                r0 = '{token_kind: {2'b00, pk_reg}, char_out: pc_reg,
                       token_first: pf_reg, token_last: 1'b0, run_last: 1'b1};
                any      = 1'b1;
                pv_next  = 1'b1;
                pk_next  = pk_reg;
                pf_next  = 1'b0;
                len_next = len_reg + LenW'(1);
            end else if (!eoi && !full && pk_reg == ets_pkg::PK_INT && c_letter) begin
                r0 = flush_res;
                r1 = '{token_kind: ets_pkg::K_NUMID, char_out: c,
                       token_first: 1'b1, token_last: 1'b1, run_last: 1'b1};
                two     = 1'b1;
                any     = 1'b1;
                pv_next = 1'b0;
            end else begin
                r0  = flush_res;
                two = f_emit;
                any = 1'b1;
            end
        end

        r0.run_last = !two;
        r1.run_last = 1'b1;
    end

    assign q_push.push     = accept && any;
    assign q_push.pair.two = two;
    assign q_push.pair.r0  = r0;
    assign q_push.pair.r1  = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg  <= 1'b0;
            pk_reg  <= ets_pkg::PK_INT;
            pf_reg  <= 1'b0;
            len_reg <= '0;
        end else if (accept) begin
            pv_reg  <= pv_next;
            pk_reg  <= pk_next;
            pf_reg  <= pf_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pc_reg <= pc_next;
        end
    end

    // held length never passes the split point
    assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> (len_reg <= LenW'(MaxTokenChars)))
        else $error("token length overrun");

    // a held add/sub character is a plus or a minus
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pv_reg && pk_reg == ets_pkg::PK_ADDSUB) |->
        (pc_reg == ets_pkg::CH_PLUS || pc_reg == ets_pkg::CH_MINUS))
        else $error("bad held add/sub character");

endmodule

/* rtl/ets_queue.sv */
// short queue of result pairs between front and back end
// depends on ets_pkg
module ets_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  ets_pkg::push_t      q_push,
    output logic                q_full,
    output logic                q_valid,
    output ets_pkg::res_pair_t  q_data,
    input  logic                q_pop
);

    localparam int Depth = ets_pkg::QUEUE_DEPTH;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    ets_pkg::res_pair_t mem [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign q_full  = (cnt_reg == CntW'(Depth));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem[rd_ptr_reg];
    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        cnt_next = cnt_reg;
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CntW'(1);
            2'b01:   cnt_next = cnt_reg - CntW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= q_push.pair;
        end
    end

    // the front end never offers a pair to a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push.push)
        else $error("push into full queue");

    // pointers and fill count agree
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == CntW'(Depth)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");

endmodule

/* rtl/ets_back.sv */
// back end: output register that hands out the one or two results of each pair
// depends on ets_pkg
module ets_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  ets_pkg::res_pair_t  q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ets_pkg::out_item_t  m_data
);

    ets_pkg::res_pair_t cur_reg;
    logic               cur_valid_reg;
    logic               idx_reg;
    logic               cur_last;
    logic               fire;

    assign m_valid  = cur_valid_reg;
    assign m_data   = idx_reg ? cur_reg.r1 : cur_reg.r0;
    assign fire     = cur_valid_reg && m_ready;
    assign cur_last = !cur_reg.two || idx_reg;
    assign q_pop    = q_valid && (!cur_valid_reg || (fire && cur_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 1'b0;
        end else if (q_pop) begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 1'b0;
        end else if (fire) begin
            if (cur_last) begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= 1'b0;
            end else begin
                idx_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
    end

    // the second slot is only shown for a pair that has two results
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid_reg && idx_reg) |-> cur_reg.two)
        else $error("second result shown for single pair");

endmodule

/* rtl/expression_token_scanner.sv */
// top level of the expression token scanner: front end, pair queue, back end
// depends on ets_pkg, ets_front, ets_queue, ets_back
// takes one character item per cycle while s_ready is high; results leave one per cycle
// from the output register while m_ready is high, after passing through the pair queue
// an item with two results holds the output for both; the 4-entry queue absorbs that
// synchronous active-low reset clears the held character, the queue and the output register
module expression_token_scanner #(
    parameter int MaxTokenChars = ets_pkg::MAX_TOKEN_CHARS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ets_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ets_pkg::out_item_t  m_data
);

    ets_pkg::push_t     q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    ets_pkg::res_pair_t q_data;

    ets_front #(
        .MaxTokenChars(MaxTokenChars)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push)
    );

    ets_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    ets_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* tb/sv/tb_expression_token_scanner.sv */
`timescale 1ns / 100ps
// self-checking testbench for expression_token_scanner: directed, token limit, output stall and random text
// depends on ets_pkg and the scanner rtl; tokens are predicted in the bench and checked per item
module tb_expression_token_scanner;

    localparam int TOKEN_LIMIT = ets_pkg::MAX_TOKEN_CHARS_DEF;
    localparam logic [7:0] OP_CHARS [9] = '{ets_pkg::CH_STAR, ets_pkg::CH_SLASH,
                                            ets_pkg::CH_EQ, ets_pkg::CH_LPAREN,
                                            ets_pkg::CH_RPAREN, ets_pkg::CH_AMP,
                                            ets_pkg::CH_BAR, ets_pkg::CH_CARET,
                                            ets_pkg::CH_MINUS};

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ets_pkg::in_item_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ets_pkg::out_item_t  m_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_req = 0;
    int hold_off_left = 0;
    int mismatches = 0;
    int items_sent = 0;

    // scanner state as predicted
    logic       held_valid = 1'b0;
    logic [7:0] held_char = '0;
    logic [1:0] held_kind = ets_pkg::PK_INT;
    logic       held_first = 1'b0;
    int         held_len = 0;

    ets_pkg::out_item_t  step_tokens[$];
    ets_pkg::out_item_t  exp_tokens[$];

    expression_token_scanner #(.MaxTokenChars(TOKEN_LIMIT)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic char_is_digit(logic [7:0] c);
        return c >= ets_pkg::CH_0 && c <= ets_pkg::CH_9;
    endfunction

    function automatic logic char_is_letter(logic [7:0] c);
        return (c >= ets_pkg::CH_LA && c <= ets_pkg::CH_LZ)
            || (c >= ets_pkg::CH_UA && c <= ets_pkg::CH_UZ) || c == ets_pkg::CH_UNDER;
    endfunction

    function automatic logic [3:0] lone_char_kind(logic [7:0] c);
        case (c)
            ets_pkg::CH_STAR, ets_pkg::CH_SLASH: return ets_pkg::K_MULDIV;
            ets_pkg::CH_EQ:                      return ets_pkg::K_ASSIGN;
            ets_pkg::CH_LPAREN:                  return ets_pkg::K_LPAREN;
            ets_pkg::CH_RPAREN:                  return ets_pkg::K_RPAREN;
            ets_pkg::CH_AMP:                     return ets_pkg::K_AND;
            ets_pkg::CH_BAR:                     return ets_pkg::K_OR;
            ets_pkg::CH_CARET:                   return ets_pkg::K_XOR;
            ets_pkg::CH_NL:                      return ets_pkg::K_EOL;
            default:                             return ets_pkg::K_SYNTAX;
        endcase
    endfunction

    function automatic logic [3:0] held_token_kind(logic [1:0] hk);
        case (hk)
            ets_pkg::PK_INT: return ets_pkg::K_INT;
            ets_pkg::PK_ID:  return ets_pkg::K_ID;
            default:         return ets_pkg::K_ADDSUB;
        endcase
    endfunction

    function automatic void add_token(logic [3:0] kind, logic [7:0] c, logic first, logic last);
        ets_pkg::out_item_t t;
        t.token_kind = kind;
        t.char_out = c;
        t.token_first = first;
        t.token_last = last;
        t.run_last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void hold_char(logic [1:0] hk, logic [7:0] c, logic first, int len);
        held_valid = 1'b1;
        held_kind = hk;
        held_char = c;
        held_first = first;
        held_len = len;
    endfunction

    function automatic void drop_held();
        held_valid = 1'b0;
        held_char = '0;
        held_kind = ets_pkg::PK_INT;
        held_first = 1'b0;
        held_len = 0;
    endfunction

    function automatic void close_held();
        add_token(held_token_kind(held_kind), held_char, held_first, 1'b1);
        drop_held();
    endfunction

    function automatic void open_token(logic [7:0] c, logic eoi);
        if (eoi) begin
            add_token(ets_pkg::K_EOF, 8'h00, 1'b1, 1'b1);
        end else if (c == ets_pkg::CH_SPACE || c == ets_pkg::CH_TAB) begin
        end else if (char_is_digit(c)) begin
            hold_char(ets_pkg::PK_INT, c, 1'b1, 1);
        end else if (char_is_letter(c)) begin
            hold_char(ets_pkg::PK_ID, c, 1'b1, 1);
        end else if (c == ets_pkg::CH_PLUS || c == ets_pkg::CH_MINUS) begin
            hold_char(ets_pkg::PK_ADDSUB, c, 1'b1, 1);
        end else begin
            add_token(lone_char_kind(c), c, 1'b1, 1'b1);
        end
    endfunction

    function automatic void predict_tokens(ets_pkg::in_item_t it);
        logic [7:0] c;
        logic       eoi;
        logic       full;
        logic       cont;
        c = it.char_in;
        eoi = it.end_of_input;
        step_tokens = {};
        if (!held_valid) begin
            open_token(c, eoi);
        end else if (held_kind == ets_pkg::PK_ADDSUB) begin
            if (!eoi && c == held_char) begin
                add_token(ets_pkg::K_INCDEC, held_char, 1'b1, 1'b0);
                add_token(ets_pkg::K_INCDEC, c, 1'b0, 1'b1);
                drop_held();
            end else begin
                close_held();
                open_token(c, eoi);
            end
        end else begin
            full = held_len >= TOKEN_LIMIT;
            cont = !eoi && !full && (held_kind == ets_pkg::PK_INT ? char_is_digit(c)
                                     : (char_is_digit(c) || char_is_letter(c)));
            if (cont) begin
                add_token(held_token_kind(held_kind), held_char, held_first, 1'b0);
                hold_char(held_kind, c, 1'b0, held_len + 1);
            end else if (!eoi && !full && held_kind == ets_pkg::PK_INT
                         && char_is_letter(c)) begin
                close_held();
                add_token(ets_pkg::K_NUMID, c, 1'b1, 1'b1);
            end else begin
                close_held();
                open_token(c, eoi);
            end
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].run_last = 1'b1;
        foreach (step_tokens[i])
            exp_tokens.push_back(step_tokens[i]);
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        mismatches++;
        $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // result checker
    always @(posedge aclk) begin
        ets_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_tokens.size() == 0) begin
                report_mismatch("unexpected item, kind", -1, m_data.token_kind);
            end else begin
                want = exp_tokens.pop_front();
                if (m_data.token_kind !== want.token_kind)
                    report_mismatch("token_kind", want.token_kind, m_data.token_kind);
                if (m_data.char_out !== want.char_out)
                    report_mismatch("char_out", want.char_out, m_data.char_out);
                if (m_data.token_first !== want.token_first)
                    report_mismatch("token_first", want.token_first, m_data.token_first);
                if (m_data.token_last !== want.token_last)
                    report_mismatch("token_last", want.token_last, m_data.token_last);
                if (m_data.run_last !== want.run_last)
                    report_mismatch("run_last", want.run_last, m_data.run_last);
            end
        end
    end

    // receiver with random stalls and long hold-offs on request
    always @(posedge aclk) begin
        if (hold_off_req > 0) begin
            hold_off_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic [7:0] c, logic eoi);
        ets_pkg::in_item_t it;
        it.char_in = c;
        it.end_of_input = eoi;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predict_tokens(it);
        items_sent++;
    endtask

    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++)
            send_item(text[i], 1'b0);
    endtask

    function automatic logic [7:0] random_digit();
        return ets_pkg::CH_0 + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(52);
        if (r < 26)
            return ets_pkg::CH_LA + 8'(r);
        else if (r < 52)
            return ets_pkg::CH_UA + 8'(r - 26);
        return ets_pkg::CH_UNDER;
    endfunction

    task automatic send_random_token();
        int r;
        int n;
        r = $urandom_range(99);
        n = $urandom_range(1, 5);
        if (r < 30) begin
            repeat (n) send_item(random_digit(), 1'b0);
        end else if (r < 50) begin
            send_item(random_letter(), 1'b0);
            repeat (n - 1)
                send_item($urandom_range(1) ? random_digit() : random_letter(), 1'b0);
        end else if (r < 64) begin
            send_item(OP_CHARS[$urandom_range(8)], 1'b0);
        end else if (r < 72) begin
            send_item($urandom_range(1) ? ets_pkg::CH_PLUS : ets_pkg::CH_MINUS, 1'b0);
            send_item($urandom_range(1) ? ets_pkg::CH_PLUS : ets_pkg::CH_MINUS, 1'b0);
        end else if (r < 80) begin
            send_item($urandom_range(1) ? ets_pkg::CH_SPACE : ets_pkg::CH_TAB, 1'b0);
        end else if (r < 85) begin
            send_item(ets_pkg::CH_NL, 1'b0);
        end else if (r < 89) begin
            repeat (n) send_item(random_digit(), 1'b0);
            send_item(random_letter(), 1'b0);
        end else if (r < 96) begin
            send_item(8'($urandom_range(255)), 1'b0);
        end else if (r < 98) begin
            send_item(8'($urandom_range(255)), 1'b1);
        end else begin
            repeat (n) send_item(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic test_directed();
        send_text("09x_aZ5++-+*/=()&|^ \t\n");
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(ets_pkg::CH_MINUS, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
    endtask

    // tokens longer than the limit are split; a letter after a full integer starts an id
    task automatic test_token_limit();
        repeat (TOKEN_LIMIT) send_item(random_digit(), 1'b0);
        send_item(ets_pkg::CH_LA + 8'd16, 1'b0);
        repeat (2 * TOKEN_LIMIT + 3)
            send_item($urandom_range(1) ? random_digit() : random_letter(), 1'b0);
        repeat (TOKEN_LIMIT + 2) send_item(random_digit(), 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_random_text(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            send_random_token();
    endtask

    task automatic test_output_stall();
        int keep_send;
        keep_send = send_idle_pct;
        send_idle_pct = 0;
        hold_off_req = 80;
        repeat (10) send_text("++a*--(1)");
        send_idle_pct = keep_send;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 14;
        recv_idle_pct = 67;
        test_directed();
        test_random_text(250);
        test_output_stall();

        send_idle_pct = 67;
        recv_idle_pct = 14;
        test_random_text(250);
        test_token_limit();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(260);
        test_output_stall();

        s_valid <= 1'b0;
        while (exp_tokens.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && exp_tokens.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
